/* src/sat_pkg.sv */
// Package for the two-polygon separating-axis collision block.
// Holds widths, vertex and pipeline types shared by every other file but sat_ram; no dependencies.
`default_nettype none

package sat_pkg;

  // Storage capacity per polygon
  localparam int unsigned MAX_VERTICES = 16;
  localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 1);

  // Arithmetic widths: coordinate, edge/axis, single product, dot product
  localparam int unsigned COORD_W = 16;
  localparam int unsigned AXIS_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = COORD_W + AXIS_W;
  localparam int unsigned DOT_W   = PROD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  // Stored vertex: x in the low half, y in the high half
  typedef struct packed {
    coord_t y;
    coord_t x;
  } vertex_t;

  localparam int unsigned VERTEX_W = $bits(vertex_t);

  // Tag that travels with each vertex read into the projection pipeline
  typedef struct packed {
    logic valid;
    logic sel;    // 0: first polygon, 1: second polygon
    logic first;  // first vertex of that polygon on this axis
  } proj_tag_t;

  // Projection unit status back to the sequencer
  typedef struct packed {
    logic busy;
    logic separated;
  } proj_stat_t;

endpackage

`default_nettype wire

/* src/sat_if.sv */
// Handshake channel interfaces: vertex input beats and result output beats.
// Depends on sat_pkg for the coordinate type.
`default_nettype none

interface sat_vtx_if;
  logic            valid;
  logic            ready;
  logic            polygon_select;
  sat_pkg::coord_t vertex_x;
  sat_pkg::coord_t vertex_y;
  logic            last_vertex;

  modport source (output valid, polygon_select, vertex_x, vertex_y, last_vertex,
                  input ready);
  modport sink   (input valid, polygon_select, vertex_x, vertex_y, last_vertex,
                  output ready);
endinterface

interface sat_res_if;
  logic valid;
  logic ready;
  logic collide;
  logic overflow;

  modport source (output valid, collide, overflow, input ready);
  modport sink   (input valid, collide, overflow, output ready);
endinterface

`default_nettype wire

/* src/sat_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency.
`default_nettype none

module sat_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* src/sat_proj.sv */
// Projection unit: dot product of streamed vertices with the current axis,
// min/max per polygon and the interval gap test. Depends on sat_pkg.
`default_nettype none

module sat_proj (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sat_pkg::proj_tag_t  tag_i,    // read issued this cycle
  input  wire sat_pkg::vertex_t    rd_a_i,   // read data, first polygon memory
  input  wire sat_pkg::vertex_t    rd_b_i,   // read data, second polygon memory
  input  wire sat_pkg::axis_t      ax_i,
  input  wire sat_pkg::axis_t      ay_i,
  output      sat_pkg::proj_stat_t stat_o
);

  sat_pkg::proj_tag_t tag1_q, tag2_q;
  sat_pkg::vertex_t   vtx;
  sat_pkg::prod_t     px_d, py_d, px_q, py_q;
  sat_pkg::dot_t      dot;
  sat_pkg::dot_t      min_a_q, max_a_q, min_b_q, max_b_q;

  // Stage 1: read data is valid, pick the memory and multiply
  assign vtx  = tag1_q.sel ? rd_b_i : rd_a_i;
  assign px_d = sat_pkg::prod_t'(vtx.x) * sat_pkg::prod_t'(ax_i);
  assign py_d = sat_pkg::prod_t'(vtx.y) * sat_pkg::prod_t'(ay_i);

  // Stage 2: sum of the products
  assign dot = sat_pkg::dot_t'(px_q) + sat_pkg::dot_t'(py_q);

  // Tag pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  // Product registers
  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
  end

  // Interval bounds per polygon
  always_ff @(posedge clk_i) begin
    if (tag2_q.valid) begin
      if (tag2_q.sel) begin
        if (tag2_q.first || dot < min_b_q) min_b_q <= dot;
        if (tag2_q.first || dot > max_b_q) max_b_q <= dot;
      end else begin
        if (tag2_q.first || dot < min_a_q) min_a_q <= dot;
        if (tag2_q.first || dot > max_a_q) max_a_q <= dot;
      end
    end
  end

  // Gap test; touching intervals overlap
  assign stat_o.busy      = tag1_q.valid | tag2_q.valid;
  assign stat_o.separated = (max_a_q < min_b_q) || (max_b_q < min_a_q);

endmodule

`default_nettype wire

/* src/sat_convex_polygon_collision_top.sv */
// Top level of the two-polygon separating-axis collision block: vertex stores,
// test sequencer and result register. Depends on sat_pkg, sat_if, sat_ram, sat_proj.
//
//   channel  dir  beat                                          handshake
//   vtx_i    in   polygon_select, vertex_x, vertex_y, last_vertex  valid/ready
//   res_o    out  collide, overflow                             valid/ready
//
// The beat with the second polygon's last vertex starts the test. For each edge
// axis the sequencer reads the edge's two vertices, sets up the axis, streams
// one read per stored vertex and drains the pipeline. Axes are tried one after
// another through the single dot-product pipeline and one read port per vertex
// memory, until one separates the polygons or all have been tried.
// ready is low while the test runs and while the result waits behind an
// undelivered one. Reset clears counts, flags and valids; vertex memories are
// not cleared.
`default_nettype none

module sat_convex_polygon_collision_top (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  sat_vtx_if.sink   vtx_i,
  sat_res_if.source res_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_E0    = 3'd1;  // read edge start vertex
  localparam logic [2:0] S_E1    = 3'd2;  // read edge end vertex
  localparam logic [2:0] S_E2    = 3'd3;  // form the axis
  localparam logic [2:0] S_PROJ  = 3'd4;  // stream vertices into projection
  localparam logic [2:0] S_DRAIN = 3'd5;  // wait for bounds, test the gap
  localparam logic [2:0] S_DONE  = 3'd6;  // hand result to the output register

  logic [2:0]          state_q, state_d;
  sat_pkg::cnt_t       cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic                ovf_q, ovf_d;
  logic                collide_q, collide_d;
  logic                ep_q, ep_d;       // polygon whose edges give the axes
  sat_pkg::idx_t       i_q, i_d;         // edge index
  logic                psel_q, psel_d;   // polygon being streamed
  sat_pkg::idx_t       k_q, k_d;         // vertex index being streamed
  sat_pkg::vertex_t    vi_q, vi_d;
  sat_pkg::axis_t      ax_q, ax_d, ay_q, ay_d;
  logic                res_valid_q, res_valid_d;
  logic                res_collide_q, res_collide_d;
  logic                res_ovf_q, res_ovf_d;

  logic                accept;
  logic                full_a, full_b;
  logic                we_a, we_b;
  sat_pkg::vertex_t    wdata;
  sat_pkg::idx_t       raddr;
  sat_pkg::vertex_t    rd_a, rd_b, rd_e;
  sat_pkg::cnt_t       n_e, n_p, i_inc, k_inc;
  sat_pkg::idx_t       j_idx;
  sat_pkg::proj_tag_t  tag;
  sat_pkg::proj_stat_t stat;

  // Input side
  assign vtx_i.ready = (state_q == S_IDLE);
  assign accept      = vtx_i.valid && vtx_i.ready;
  assign full_a      = (cnt_a_q == sat_pkg::cnt_t'(sat_pkg::MAX_VERTICES));
  assign full_b      = (cnt_b_q == sat_pkg::cnt_t'(sat_pkg::MAX_VERTICES));
  assign we_a        = accept && !vtx_i.polygon_select && !full_a;
  assign we_b        = accept &&  vtx_i.polygon_select && !full_b;
  assign wdata       = '{y: vtx_i.vertex_y, x: vtx_i.vertex_x};

  // Edge and vertex indexing
  assign n_e   = ep_q ? cnt_b_q : cnt_a_q;
  assign n_p   = psel_q ? cnt_b_q : cnt_a_q;
  assign i_inc = sat_pkg::cnt_t'(i_q) + sat_pkg::cnt_t'(1);
  assign k_inc = sat_pkg::cnt_t'(k_q) + sat_pkg::cnt_t'(1);
  assign j_idx = (i_inc == n_e) ? '0 : i_inc[sat_pkg::IDX_W-1:0];
  assign rd_e  = ep_q ? rd_b : rd_a;

  // Shared read address for both vertex memories
  always_comb begin
    unique case (state_q)
      S_E0:    raddr = i_q;
      S_E1:    raddr = j_idx;
      S_PROJ:  raddr = k_q;
      default: raddr = '0;
    endcase
  end

  sat_ram #(
    .DEPTH (sat_pkg::MAX_VERTICES),
    .WIDTH (sat_pkg::VERTEX_W)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[sat_pkg::IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  sat_ram #(
    .DEPTH (sat_pkg::MAX_VERTICES),
    .WIDTH (sat_pkg::VERTEX_W)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[sat_pkg::IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

  sat_proj u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag),
    .rd_a_i (rd_a),
    .rd_b_i (rd_b),
    .ax_i   (ax_q),
    .ay_i   (ay_q),
    .stat_o (stat)
  );

  // Sequencer
  always_comb begin
    state_d       = state_q;
    cnt_a_d       = cnt_a_q;
    cnt_b_d       = cnt_b_q;
    ovf_d         = ovf_q;
    collide_d     = collide_q;
    ep_d          = ep_q;
    i_d           = i_q;
    psel_d        = psel_q;
    k_d           = k_q;
    vi_d          = vi_q;
    ax_d          = ax_q;
    ay_d          = ay_q;
    res_valid_d   = res_valid_q && !res_o.ready;
    res_collide_d = res_collide_q;
    res_ovf_d     = res_ovf_q;
    tag           = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!vtx_i.polygon_select) begin
            if (!full_a) cnt_a_d = cnt_a_q + sat_pkg::cnt_t'(1);
            else         ovf_d   = 1'b1;
          end else begin
            if (!full_b) cnt_b_d = cnt_b_q + sat_pkg::cnt_t'(1);
            else         ovf_d   = 1'b1;
            if (vtx_i.last_vertex) begin
              // An empty first polygon never collides
              if (cnt_a_q == '0) begin
                collide_d = 1'b0;
                state_d   = S_DONE;
              end else begin
                ep_d    = 1'b0;
                i_d     = '0;
                state_d = S_E0;
              end
            end
          end
        end
      end
      S_E0: begin
        state_d = S_E1;
      end
      S_E1: begin
        vi_d    = rd_e;
        state_d = S_E2;
      end
      S_E2: begin
        // Axis is the edge normal (-ey, ex)
        ax_d    = sat_pkg::axis_t'(vi_q.y) - sat_pkg::axis_t'(rd_e.y);
        ay_d    = sat_pkg::axis_t'(rd_e.x) - sat_pkg::axis_t'(vi_q.x);
        psel_d  = 1'b0;
        k_d     = '0;
        state_d = S_PROJ;
      end
      S_PROJ: begin
        tag.valid = 1'b1;
        tag.sel   = psel_q;
        tag.first = (k_q == '0);
        if (k_inc == n_p) begin
          k_d = '0;
          if (!psel_q) psel_d  = 1'b1;
          else         state_d = S_DRAIN;
        end else begin
          k_d = k_inc[sat_pkg::IDX_W-1:0];
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          if (stat.separated) begin
            collide_d = 1'b0;
            state_d   = S_DONE;
          end else if (i_inc == n_e) begin
            i_d = '0;
            if (!ep_q) begin
              ep_d    = 1'b1;
              state_d = S_E0;
            end else begin
              collide_d = 1'b1;
              state_d   = S_DONE;
            end
          end else begin
            i_d     = i_inc[sat_pkg::IDX_W-1:0];
            state_d = S_E0;
          end
        end
      end
      S_DONE: begin
        // Wait for the output register to be free, then start a new pair
        if (!res_valid_q || res_o.ready) begin
          res_valid_d   = 1'b1;
          res_collide_d = collide_q;
          res_ovf_d     = ovf_q;
          cnt_a_d       = '0;
          cnt_b_d       = '0;
          ovf_d         = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ovf_q       <= 1'b0;
      ep_q        <= 1'b0;
      i_q         <= '0;
      psel_q      <= 1'b0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ovf_q       <= ovf_d;
      ep_q        <= ep_d;
      i_q         <= i_d;
      psel_q      <= psel_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    collide_q     <= collide_d;
    vi_q          <= vi_d;
    ax_q          <= ax_d;
    ay_q          <= ay_d;
    res_collide_q <= res_collide_d;
    res_ovf_q     <= res_ovf_d;
  end

  // Output side
  assign res_o.valid    = res_valid_q;
  assign res_o.collide  = res_collide_q;
  assign res_o.overflow = res_ovf_q;

endmodule

`default_nettype wire

/* verif/sat_collision_checker.sv */
// Scoreboard for the two-polygon separating-axis collision block.
// Watches the vertex and result channels, predicts each verdict and compares.
// Depends on sat_pkg and the channel interfaces in sat_if.
module sat_collision_checker
  import sat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sat_vtx_if          vtx_i,
  sat_res_if          res_i,
  output int unsigned mismatch_count_o,
  output int unsigned verdicts_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic collide;
    logic overflow;
  } verdict_t;

  // Shadow copy of the block's vertex stores
  vertex_t     store_a [MAX_VERTICES];
  vertex_t     store_b [MAX_VERTICES];
  int unsigned count_a;
  int unsigned count_b;
  bit          too_many;

  verdict_t    verdicts_due[$];
  int unsigned mismatches;

  // Min and max of the dot products of one polygon's vertices with an axis
  function automatic void project_span(input bit of_b, input longint ax, input longint ay,
                                       output longint lo, output longint hi);
    int unsigned n;
    longint      d;
    vertex_t     v;
    n  = of_b ? count_b : count_a;
    lo = 0;
    hi = 0;
    for (int unsigned i = 0; i < n; i++) begin
      v = of_b ? store_b[i] : store_a[i];
      d = longint'($signed(v.x)) * ax + longint'($signed(v.y)) * ay;
      if (i == 0 || d < lo) lo = d;
      if (i == 0 || d > hi) hi = d;
    end
  endfunction

  // True when some edge normal of the chosen polygon leaves a gap
  function automatic bit separating_edge(input bit of_b);
    int unsigned n;
    int unsigned j;
    vertex_t     p;
    vertex_t     q;
    longint      ax;
    longint      ay;
    longint      lo_a;
    longint      hi_a;
    longint      lo_b;
    longint      hi_b;
    n = of_b ? count_b : count_a;
    for (int unsigned i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      p  = of_b ? store_b[i] : store_a[i];
      q  = of_b ? store_b[j] : store_a[j];
      ax = -(longint'($signed(q.y)) - longint'($signed(p.y)));
      ay = longint'($signed(q.x)) - longint'($signed(p.x));
      project_span(1'b0, ax, ay, lo_a, hi_a);
      project_span(1'b1, ax, ay, lo_b, hi_b);
      if (hi_a < lo_b || hi_b < lo_a) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string what, input verdict_t want, input verdict_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: result mismatch (%s): expected collide=%0b overflow=%0b, %s%0b %s%0b",
               $time, what, want.collide, want.overflow,
               "got collide=", got.collide, "overflow=", got.overflow);
  endtask

  // Track accepted beats on both channels
  always @(posedge clk_i) begin : watch
    vertex_t  v;
    verdict_t got;
    verdict_t want;
    if (!rst_ni) begin
      count_a  = 0;
      count_b  = 0;
      too_many = 1'b0;
      verdicts_due.delete();
    end else begin
      // Result beat against the oldest pending verdict
      if (res_i.valid && res_i.ready) begin
        got.collide  = res_i.collide;
        got.overflow = res_i.overflow;
        if (verdicts_due.size() == 0) begin
          flag_mismatch("no result pending", '0, got);
        end else begin
          want = verdicts_due.pop_front();
          if (got.collide !== want.collide || got.overflow !== want.overflow)
            flag_mismatch("wrong field", want, got);
        end
      end
      // Vertex beat: store, and on the second polygon's last vertex run the test
      if (vtx_i.valid && vtx_i.ready) begin
        v.x = vtx_i.vertex_x;
        v.y = vtx_i.vertex_y;
        if (!vtx_i.polygon_select) begin
          if (count_a < MAX_VERTICES) begin
            store_a[count_a] = v;
            count_a++;
          end else begin
            too_many = 1'b1;
          end
        end else begin
          if (count_b < MAX_VERTICES) begin
            store_b[count_b] = v;
            count_b++;
          end else begin
            too_many = 1'b1;
          end
          if (vtx_i.last_vertex) begin
            // an empty polygon never collides
            if (count_a == 0 || count_b == 0) want.collide = 1'b0;
            else want.collide = !(separating_edge(1'b0) || separating_edge(1'b1));
            want.overflow = too_many;
            verdicts_due.insert(verdicts_due.size(), want);
            count_a  = 0;
            count_b  = 0;
            too_many = 1'b0;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    verdicts_due_o   <= verdicts_due.size();
  end

  initial mismatches = 0;

endmodule

/* verif/sat_convex_polygon_collision_top_test.sv */
// Testbench top for sat_convex_polygon_collision_top: clock, reset, vertex stimulus,
// result-side stalls, watchdog and verdict. Checking lives in sat_collision_checker.
// Depends on sat_pkg, sat_if and the block's RTL.
module sat_convex_polygon_collision_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sat_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1900;
  localparam int unsigned HOLDOFF_CYCLES  = 400;
  localparam int unsigned SETTLE_CYCLES   = 1300;   // covers the longest test, with both polygons full
  localparam int unsigned WATCHDOG_CYCLES = 20000;
  localparam real         TWO_PI          = 6.283185307179586;

  typedef struct {
    bit     sel;
    coord_t x;
    coord_t y;
    bit     last;
  } vertex_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sat_vtx_if vtx ();
  sat_res_if res ();

  int unsigned  mismatch_count;
  int unsigned  verdicts_due;
  int unsigned  items_sent;
  int unsigned  src_idle_pct;
  int unsigned  sink_stall_pct;
  int unsigned  idle_cycles;
  bit           holdoff_flip;
  vertex_beat_t beat_q[$];

  sat_convex_polygon_collision_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx),
    .res_o  (res)
  );

  sat_collision_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .vtx_i            (vtx),
    .res_i            (res),
    .mismatch_count_o (mismatch_count),
    .verdicts_due_o   (verdicts_due)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((vtx.valid && vtx.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("** sat_convex_polygon_collision_top: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    bit seen_flip;
    seen_flip = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_flip != seen_flip) begin
        seen_flip = holdoff_flip;
        res.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
      end
      res.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic add_vertex(input bit sel, input int x, input int y, input bit last);
    vertex_beat_t b;
    b.sel  = sel;
    b.x    = coord_t'(x);
    b.y    = coord_t'(y);
    b.last = last;
    beat_q.insert(beat_q.size(), b);
  endtask

  // Points on an ellipse in angular order, clamped to the coordinate range
  task automatic add_convex(input bit sel, input int unsigned n, input int cx, input int cy,
                            input int rx, input int ry, input bit last_on_end);
    real phase;
    real ang;
    int  px;
    int  py;
    phase = TWO_PI * $urandom_range(999) / 1000.0;
    for (int unsigned k = 0; k < n; k++) begin
      ang = phase + TWO_PI * (k + $urandom_range(70) / 100.0) / n;
      px  = cx + int'(rx * $cos(ang));
      py  = cy + int'(ry * $sin(ang));
      if (px > 32767) px = 32767;
      if (px < -32768) px = -32768;
      if (py > 32767) py = 32767;
      if (py < -32768) py = -32768;
      add_vertex(sel, px, py, last_on_end && (k == n - 1));
    end
  endtask

  // Mostly small polygons, a few at capacity or beyond it
  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return $urandom_range(1, 2);
    if (r < 84) return $urandom_range(3, 6);
    if (r < 96) return $urandom_range(7, MAX_VERTICES);
    return $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 4);
  endfunction

  // One polygon pair, always closed by the second polygon's last vertex
  task automatic make_pair();
    int unsigned  kind;
    int unsigned  na;
    int unsigned  nb;
    int           cx;
    int           cy;
    int           ra;
    int           rb;
    int           span;
    int           j;
    vertex_beat_t tmp;
    kind = $urandom_range(99);
    if (kind < 75 || kind >= 88) begin
      na = pick_count();
      nb = pick_count();
      if (kind < 65 || kind >= 88) begin
        ra = $urandom_range(4, 3000);
        rb = $urandom_range(4, 3000);
        cx = int'($urandom_range(40000)) - 20000;
        cy = int'($urandom_range(40000)) - 20000;
      end else begin
        // near full-range shapes hit the coordinate extremes
        ra = $urandom_range(16000, 40000);
        rb = $urandom_range(16000, 40000);
        cx = int'($urandom_range(16000)) - 8000;
        cy = int'($urandom_range(16000)) - 8000;
      end
      span = (ra + rb) * 5 / 4;
      add_convex(1'b0, na, cx, cy, ra, ra * int'($urandom_range(50, 100)) / 100, 1'b1);
      add_convex(1'b1, nb, cx + int'($urandom_range(2 * span)) - span,
                 cy + int'($urandom_range(2 * span)) - span,
                 rb, rb * int'($urandom_range(50, 100)) / 100, 1'b1);
      if (kind >= 88) begin
        // broken order: vertices interleaved, first polygon's flag lands anywhere
        for (int i = beat_q.size() - 2; i > 0; i--) begin
          j         = $urandom_range(i);
          tmp       = beat_q[i];
          beat_q[i] = beat_q[j];
          beat_q[j] = tmp;
        end
      end
    end else begin
      // noise: full-range coordinates, random flags on A, sometimes no A at all
      na = $urandom_range(0, 6);
      nb = $urandom_range(1, 6);
      for (int unsigned k = 0; k < na; k++)
        add_vertex(1'b0, int'($urandom), int'($urandom), $urandom_range(1));
      for (int unsigned k = 0; k < nb; k++)
        add_vertex(1'b1, int'($urandom), int'($urandom), k == nb - 1);
    end
  endtask

  task automatic send_beat(input vertex_beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      vtx.valid <= 1'b0;
      @(posedge clk_i);
    end
    vtx.valid          <= 1'b1;
    vtx.polygon_select <= b.sel;
    vtx.vertex_x       <= b.x;
    vtx.vertex_y       <= b.y;
    vtx.last_vertex    <= b.last;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_queued();
    while (beat_q.size() != 0) send_beat(beat_q.pop_front());
  endtask

  // Stop offering and wait for every pending verdict
  task automatic drain();
    vtx.valid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bit held;
    held                = 1'b0;
    items_sent          = 0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    idle_cycles         = 0;
    holdoff_flip        = 1'b0;
    vtx.valid          <= 1'b0;
    vtx.polygon_select <= 1'b0;
    vtx.vertex_x       <= '0;
    vtx.vertex_y       <= '0;
    vtx.last_vertex    <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty first polygon
    add_vertex(1'b1, 7, -7, 1'b1);
    // Two single points at the origin: only null axes, so they collide
    add_vertex(1'b0, 0, 0, 1'b1);
    add_vertex(1'b1, 0, 0, 1'b1);
    // Coordinate extremes
    add_vertex(1'b0, -32768, -32768, 1'b0);
    add_vertex(1'b0, 32767, -32768, 1'b0);
    add_vertex(1'b0, 32767, 32767, 1'b1);
    add_vertex(1'b1, -32768, 32767, 1'b0);
    add_vertex(1'b1, -1, 0, 1'b1);
    // Squares sharing an edge: touching counts as overlap
    add_vertex(1'b0, 0, 0, 1'b0);
    add_vertex(1'b0, 10, 0, 1'b0);
    add_vertex(1'b0, 10, 10, 1'b0);
    add_vertex(1'b0, 0, 10, 1'b1);
    add_vertex(1'b1, 10, 0, 1'b0);
    add_vertex(1'b1, 20, 0, 1'b0);
    add_vertex(1'b1, 20, 10, 1'b0);
    add_vertex(1'b1, 10, 10, 1'b1);
    // Well apart, with a repeated vertex giving a zero-length edge in B
    add_vertex(1'b0, 0, 0, 1'b0);
    add_vertex(1'b0, 5, 0, 1'b0);
    add_vertex(1'b0, 0, 5, 1'b1);
    add_vertex(1'b1, 100, 100, 1'b0);
    add_vertex(1'b1, 100, 100, 1'b0);
    add_vertex(1'b1, 101, 100, 1'b0);
    add_vertex(1'b1, 100, 101, 1'b1);
    send_queued();
    drain();

    // Random pairs over four idling phases
    for (int unsigned ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 50;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 50;
        end
        default: begin
          src_idle_pct   = 37;
          sink_stall_pct = 37;
        end
      endcase
      while (items_sent < (ph + 1) * RANDOM_ITEMS / 4) begin
        make_pair();
        send_queued();
        // long result hold-off while vertices keep coming
        if (ph == 0 && !held && items_sent >= 100) begin
          holdoff_flip <= ~holdoff_flip;
          held = 1'b1;
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && verdicts_due == 0)
      $display("** sat_convex_polygon_collision_top: PASSED **");
    else
      $display("** sat_convex_polygon_collision_top: FAILED **");
    $finish;
  end

endmodule
